FILE: hdl/nsld_pkg.sv
// Shared types and constants for the network status LED driver.
package nsld_pkg;

  typedef enum logic [1:0] {
    MODE_INITIAL      = 2'd0,
    MODE_DISCONNECTED = 2'd1,
    MODE_CONNECTING   = 2'd2,
    MODE_CONNECTED    = 2'd3
  } mode_t;

  localparam logic REQ_TICK  = 1'b0;
  localparam logic REQ_EVENT = 1'b1;

  localparam logic [2:0] EV_START        = 3'd0;
  localparam logic [2:0] EV_ASSOCIATED   = 3'd1;
  localparam logic [2:0] EV_GOT_ADDRESS  = 3'd2;
  localparam logic [2:0] EV_DISCONNECTED = 3'd3;
  localparam logic [2:0] EV_STOPPED      = 3'd4;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOW_PERIOD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FAST_PERIOD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RAMP_PERIOD = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RAMP_FLOOR  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RAMP_CEIL   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RAMP_INCR   = 3'd5;

  localparam logic [7:0]  DUTY_FULL = 8'd255;
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  typedef struct packed {
    logic [15:0] slow_period;
    logic [15:0] fast_period;
    logic [15:0] ramp_period;
    logic [7:0]  ramp_floor;
    logic [7:0]  ramp_ceiling;
    logic [7:0]  ramp_increment;
  } cfg_t;

  typedef struct packed {
    mode_t       mode;
    logic [15:0] since_change;
    logic        blink_on;
    logic [8:0]  ramp_level;
    logic        ramp_rising;
    logic [7:0]  duty_now;
  } state_t;

  typedef struct packed {
    logic [7:0] duty;
    logic       duty_written;
    mode_t      link_mode;
  } result_t;

endpackage

FILE: hdl/network_status_led_driver.sv
// Top level of the network status LED driver: state, config and output staging.
//
//   channel | direction | handshake             | word
//   in_     | input     | in_valid / in_stall   | req_type, event_code, force_off
//   out_    | output    | out_valid / out_stall | duty, duty_written, link_mode
//   cfg_    | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One word is taken per cycle while in_stall is low; its result is registered
// in out_r, or parked in the skid register behind it while out_r is occupied.
// The combinational update in nsld_step sets this rate. The skid keeps the
// input open for one more word; in_stall rises only when the skid is full.
// rst_n (synchronous, active low) restores the default config and idle state.
module network_status_led_driver (
  input  logic       clk,
  input  logic       rst_n,
  // input words
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_req_type,
  input  logic [2:0] in_event_code,
  input  logic       in_force_off,
  // result words
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_duty,
  output logic       out_duty_written,
  output logic [1:0] out_link_mode,
  // config writes
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [15:0] cfg_data
);
  import nsld_pkg::*;

  cfg_t    cfg_r,   cfg_nxt;
  state_t  state_r, state_step;
  result_t res_step;
  result_t out_r,   out_nxt;
  result_t skid_r,  skid_nxt;
  logic    out_valid_r,  out_valid_nxt;
  logic    skid_valid_r, skid_valid_nxt;
  logic    in_acc, out_take;

  // Config writes are always taken; unknown indexes are dropped.
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_SLOW_PERIOD: cfg_nxt.slow_period    = cfg_data;
        CFG_FAST_PERIOD: cfg_nxt.fast_period    = cfg_data;
        CFG_RAMP_PERIOD: cfg_nxt.ramp_period    = cfg_data;
        CFG_RAMP_FLOOR:  cfg_nxt.ramp_floor     = cfg_data[7:0];
        CFG_RAMP_CEIL:   cfg_nxt.ramp_ceiling   = cfg_data[7:0];
        CFG_RAMP_INCR:   cfg_nxt.ramp_increment = cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Compute the next pattern state and this word's result.
  nsld_step u_step (
    .cfg        (cfg_r),
    .cur        (state_r),
    .req_type   (in_req_type),
    .event_code (in_event_code),
    .force_off  (in_force_off),
    .nxt        (state_step),
    .res        (res_step)
  );

  assign in_stall = skid_valid_r;
  assign in_acc   = in_valid && !skid_valid_r;
  assign out_take = out_valid_r && !out_stall;

  // Output staging: refill from skid first, else from the new word; park the
  // new word in the skid when the output register stays occupied.
  always_comb begin
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r;
    skid_nxt       = skid_r;
    skid_valid_nxt = skid_valid_r;
    if (out_take || !out_valid_r) begin
      if (skid_valid_r) begin
        out_nxt        = skid_r;
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end else if (in_acc) begin
        out_nxt       = res_step;
        out_valid_nxt = 1'b1;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end else if (in_acc) begin
      skid_nxt       = res_step;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.slow_period    <= 16'd1000;
      cfg_r.fast_period    <= 16'd200;
      cfg_r.ramp_period    <= 16'd20;
      cfg_r.ramp_floor     <= 8'd0;
      cfg_r.ramp_ceiling   <= 8'd255;
      cfg_r.ramp_increment <= 8'd5;
      state_r.mode         <= MODE_INITIAL;
      state_r.since_change <= '0;
      state_r.blink_on     <= 1'b0;
      state_r.ramp_level   <= '0;
      state_r.ramp_rising  <= 1'b1;
      state_r.duty_now     <= '0;
      out_valid_r          <= 1'b0;
      skid_valid_r         <= 1'b0;
    end else begin
      cfg_r        <= cfg_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
      // advance the pattern only on an accepted word
      if (in_acc) begin
        state_r <= state_step;
      end
    end
  end

  // Payload registers hold without reset.
  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_duty         = out_r.duty;
  assign out_duty_written = out_r.duty_written;
  assign out_link_mode    = out_r.link_mode;

endmodule

FILE: hdl/nsld_step.sv
// Next-state and result logic for one tick or link event.
module nsld_step (
  input  nsld_pkg::cfg_t    cfg,
  input  nsld_pkg::state_t  cur,
  input  logic              req_type,
  input  logic [2:0]        event_code,
  input  logic              force_off,
  output nsld_pkg::state_t  nxt,
  output nsld_pkg::result_t res
);
  import nsld_pkg::*;

  logic [15:0]       count_inc;
  logic [15:0]       period;
  logic [9:0]        rise_sum;
  logic signed [10:0] fall_diff;
  logic              written;

  always_comb begin
    nxt       = cur;
    written   = 1'b0;
    count_inc = (cur.since_change == COUNT_MAX) ? cur.since_change
                                                : cur.since_change + 16'd1;
    case (cur.mode)
      MODE_CONNECTING: period = cfg.fast_period;
      MODE_CONNECTED:  period = cfg.ramp_period;
      default:         period = cfg.slow_period;
    endcase
    rise_sum  = {1'b0, cur.ramp_level} + {2'b00, cfg.ramp_increment};
    fall_diff = $signed({2'b00, cur.ramp_level}) - $signed({3'b000, cfg.ramp_increment});

    if (req_type == REQ_EVENT) begin
      case (event_code)
        EV_START:      nxt.mode = MODE_INITIAL;
        EV_ASSOCIATED: nxt.mode = MODE_CONNECTING;
        EV_GOT_ADDRESS: begin
          nxt.mode        = MODE_CONNECTED;
          nxt.ramp_level  = {1'b0, cfg.ramp_floor};
          nxt.ramp_rising = 1'b1;
        end
        EV_DISCONNECTED, EV_STOPPED: nxt.mode = MODE_DISCONNECTED;
        default: ;
      endcase
    end else begin
      nxt.since_change = count_inc;
      if (force_off) begin
        nxt.duty_now = '0;
        written      = 1'b1;
      end else if (count_inc >= period) begin
        nxt.since_change = '0;
        written          = 1'b1;
        if (cur.mode == MODE_CONNECTED) begin
          // drive the current level, then step and turn around at the limits
          nxt.duty_now = cur.ramp_level[7:0];
          if (cur.ramp_rising) begin
            if (rise_sum >= {2'b00, cfg.ramp_ceiling}) begin
              nxt.ramp_level  = {1'b0, cfg.ramp_ceiling};
              nxt.ramp_rising = 1'b0;
            end else begin
              nxt.ramp_level = rise_sum[8:0];
            end
          end else begin
            if (fall_diff <= $signed({3'b000, cfg.ramp_floor})) begin
              nxt.ramp_level  = {1'b0, cfg.ramp_floor};
              nxt.ramp_rising = 1'b1;
            end else begin
              nxt.ramp_level = fall_diff[8:0];
            end
          end
        end else begin
          nxt.blink_on = ~cur.blink_on;
          nxt.duty_now = cur.blink_on ? '0 : DUTY_FULL;
        end
      end
    end

    res.duty         = nxt.duty_now;
    res.duty_written = written;
    res.link_mode    = nxt.mode;
  end

endmodule

FILE: dv/tb.sv
// Self-checking testbench for the network status LED driver: predicts duty and mode per word.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import nsld_pkg::*;

  // Cycles in a row with no handshake taken before the run is declared hung.
  // The longest legal quiet stretch is the long receiver hold-off (LONG_HOLD)
  // plus a sender and a receiver idle burst.
  localparam int QUIET_LIMIT   = 2000;
  // Longest output stall; long enough to fill the output and skid registers.
  localparam int LONG_HOLD     = 60;
  localparam int PHASE_WORDS   = 175;
  localparam int RANDOM_PHASES = 6;
  // Cap on printed mismatch lines; all mismatches still count.
  localparam int PRINT_CAP     = 50;

  // Track the LED pattern: mirror of the block state plus the results awaited.
  class led_pattern_tracker;
    cfg_t        regs;
    mode_t       mode;
    logic [15:0] elapsed;
    logic        blink_on;
    logic [8:0]  level;
    logic        rising;
    logic [7:0]  duty;
    result_t     awaited[$];
    int          mismatches;

    function new();
      regs.slow_period    = 16'd1000;
      regs.fast_period    = 16'd200;
      regs.ramp_period    = 16'd20;
      regs.ramp_floor     = 8'd0;
      regs.ramp_ceiling   = 8'd255;
      regs.ramp_increment = 8'd5;
      mode       = MODE_INITIAL;
      elapsed    = '0;
      blink_on   = 1'b0;
      level      = '0;
      rising     = 1'b1;
      duty       = '0;
      mismatches = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [15:0] data);
      case (idx)
        CFG_SLOW_PERIOD: regs.slow_period    = data;
        CFG_FAST_PERIOD: regs.fast_period    = data;
        CFG_RAMP_PERIOD: regs.ramp_period    = data;
        CFG_RAMP_FLOOR:  regs.ramp_floor     = data[7:0];
        CFG_RAMP_CEIL:   regs.ramp_ceiling   = data[7:0];
        CFG_RAMP_INCR:   regs.ramp_increment = data[7:0];
        default: ;
      endcase
    endfunction

    // Advance the pattern by one accepted word and queue the result it causes.
    function void note_word(logic req, logic [2:0] code, logic frc);
      logic [15:0] period;
      int          lvl;
      int          lo;
      int          hi;
      int          step;
      result_t     r;
      r.duty_written = 1'b0;
      if (req == REQ_EVENT) begin
        case (code)
          EV_START:      mode = MODE_INITIAL;
          EV_ASSOCIATED: mode = MODE_CONNECTING;
          EV_GOT_ADDRESS: begin
            mode   = MODE_CONNECTED;
            level  = {1'b0, regs.ramp_floor};
            rising = 1'b1;
          end
          EV_DISCONNECTED, EV_STOPPED: mode = MODE_DISCONNECTED;
          default: ;
        endcase
      end else begin
        if (elapsed != COUNT_MAX) elapsed++;
        if (frc) begin
          duty           = '0;
          r.duty_written = 1'b1;
        end else begin
          if (mode == MODE_CONNECTING) period = regs.fast_period;
          else if (mode == MODE_CONNECTED) period = regs.ramp_period;
          else period = regs.slow_period;
          if (elapsed >= period) begin
            if (mode == MODE_CONNECTED) begin
              duty = level[7:0];
              lvl  = int'(level);
              lo   = int'(regs.ramp_floor);
              hi   = int'(regs.ramp_ceiling);
              step = int'(regs.ramp_increment);
              if (rising) begin
                lvl = lvl + step;
                if (lvl >= hi) begin
                  lvl    = hi;
                  rising = 1'b0;
                end
              end else begin
                lvl = lvl - step;
                if (lvl <= lo) begin
                  lvl    = lo;
                  rising = 1'b1;
                end
              end
              level = lvl[8:0];
            end else begin
              blink_on = ~blink_on;
              duty     = blink_on ? DUTY_FULL : 8'd0;
            end
            elapsed        = '0;
            r.duty_written = 1'b1;
          end
        end
      end
      r.duty      = duty;
      r.link_mode = mode;
      awaited = {awaited, r};
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= PRINT_CAP) $display("%0t ns: MISMATCH %s", $time, msg);
    endtask

    task check_result(logic [7:0] d, logic w, logic [1:0] m);
      result_t want;
      if (awaited.size() == 0) begin
        report($sformatf("result word with nothing awaited (duty %0d)", d));
        return;
      end
      want = awaited.pop_front();
      if (d !== want.duty)
        report($sformatf("duty %0d, expected %0d", d, want.duty));
      if (w !== want.duty_written)
        report($sformatf("duty_written %0b, expected %0b", w, want.duty_written));
      if (m !== want.link_mode)
        report($sformatf("link_mode %0d, expected %0d", m, want.link_mode));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_req_type = REQ_TICK;
  logic [2:0]  in_event_code = EV_START;
  logic        in_force_off = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_duty;
  logic        out_duty_written;
  logic [1:0]  out_link_mode;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = CFG_SLOW_PERIOD;
  logic [15:0] cfg_data = '0;

  led_pattern_tracker sb;

  // Idle controls shared between the stimulus and the receiver.
  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  int rx_hold = 0;
  int sent_words = 0;
  int quiet_cycles = 0;
  bit took_any;

  network_status_led_driver uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_type      (in_req_type),
    .in_event_code    (in_event_code),
    .in_force_off     (in_force_off),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_duty         (out_duty),
    .out_duty_written (out_duty_written),
    .out_link_mode    (out_link_mode),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Sample every handshake at the rising edge, before the block's own
  // updates land, so the values seen are the ones the block acted on.
  // The same block runs the watchdog on cycles with no handshake taken.
  always @(posedge clk) begin
    if (rst_n) begin
      took_any = 1'b0;
      if (in_valid && !in_stall) begin
        sb.note_word(in_req_type, in_event_code, in_force_off);
        took_any = 1'b1;
      end
      if (out_valid && !out_stall) begin
        sb.check_result(out_duty, out_duty_written, out_link_mode);
        took_any = 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        sb.set_reg(cfg_index, cfg_data);
        took_any = 1'b1;
      end
      if (took_any) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Receiver: stall in random bursts, with a calm stretch in every period of the
  // cyc counter; a hold-off request from the stimulus wins over both.
  initial begin : receiver
    int stall_left;
    int cyc;
    stall_left = 0;
    cyc = 0;
    forever begin
      @(negedge clk);
      cyc++;
      if (rx_hold > 0) begin
        out_stall <= 1'b1;
        rx_hold--;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (rx_idle_on && (cyc % 128) < 90 && $urandom_range(0, 5) == 0) begin
        out_stall  <= 1'b1;
        stall_left = $urandom_range(1, 9) - 1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Offer one word, possibly after a random idle burst, and hold it until
  // the block takes it. Valid stays high on return so back-to-back words
  // never lower and raise it within one step.
  task automatic send_word(input logic req, input logic [2:0] code, input logic frc);
    int gap;
    if (tx_idle_on && (sent_words % 64) < 40 && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 9);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    end
    @(negedge clk);
    in_valid      <= 1'b1;
    in_req_type   <= req;
    in_event_code <= code;
    in_force_off  <= frc;
    do @(posedge clk); while (in_stall);
    sent_words++;
  endtask

  // Drop valid and wait at falling edges, after all rising-edge checks
  // have run, until every awaited result has come back.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.awaited.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Write all six registers; the 8-bit ones carry junk in the upper byte,
  // which the block must drop.
  task automatic load_settings(input logic [15:0] slow, input logic [15:0] fast,
                               input logic [15:0] ramp, input logic [7:0] lo,
                               input logic [7:0] hi, input logic [7:0] step);
    write_reg(CFG_SLOW_PERIOD, slow);
    write_reg(CFG_FAST_PERIOD, fast);
    write_reg(CFG_RAMP_PERIOD, ramp);
    write_reg(CFG_RAMP_FLOOR, {8'($urandom), lo});
    write_reg(CFG_RAMP_CEIL, {8'($urandom), hi});
    write_reg(CFG_RAMP_INCR, {8'($urandom), step});
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly ticks; events lean toward got-address so the ramp gets exercised,
  // and the unknown codes still show up. Ticks carry a random code too.
  task automatic send_random_word();
    logic       req;
    logic [2:0] code;
    logic       frc;
    int         pick;
    req  = ($urandom_range(0, 99) < 25) ? REQ_EVENT : REQ_TICK;
    pick = $urandom_range(0, 9);
    code = (pick > 7) ? EV_GOT_ADDRESS : 3'(pick);
    frc  = ($urandom_range(0, 7) == 0);
    send_word(req, code, frc);
  endtask

  initial begin
    sb = new();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset defaults: long periods, so nothing but held levels and modes.
    send_word(REQ_TICK, EV_START, 1'b0);
    send_word(REQ_EVENT, EV_GOT_ADDRESS, 1'b0);
    send_word(REQ_TICK, EV_START, 1'b0);
    drain_results();

    // Directed: zero slow period, unit periods elsewhere, full-swing ramp.
    load_settings(16'd0, 16'd1, 16'd1, 8'd0, 8'd255, 8'd255);
    send_word(REQ_TICK, EV_START, 1'b0);        // blink on every tick
    send_word(REQ_TICK, EV_START, 1'b1);        // forced dark
    send_word(REQ_TICK, EV_START, 1'b0);
    send_word(REQ_EVENT, EV_ASSOCIATED, 1'b0);
    send_word(REQ_TICK, EV_START, 1'b0);
    send_word(REQ_TICK, EV_START, 1'b0);
    send_word(REQ_EVENT, EV_GOT_ADDRESS, 1'b0); // ramp restarts at floor
    send_word(REQ_TICK, EV_START, 1'b0);        // clamp at ceiling
    send_word(REQ_TICK, EV_START, 1'b0);        // clamp at floor
    send_word(REQ_TICK, EV_START, 1'b0);
    send_word(REQ_EVENT, EV_DISCONNECTED, 1'b0);
    send_word(REQ_TICK, EV_START, 1'b0);
    send_word(REQ_EVENT, EV_GOT_ADDRESS, 1'b1); // force ignored on events
    send_word(REQ_EVENT, EV_STOPPED, 1'b0);
    for (int k = 1; k <= 3; k++)
      send_word(REQ_EVENT, 3'(EV_STOPPED + k), 1'b0);  // unknown codes
    send_word(REQ_TICK, 3'(EV_STOPPED + 3), 1'b0);     // code ignored on ticks
    send_word(REQ_EVENT, EV_START, 1'b0);
    send_word(REQ_TICK, EV_START, 1'b1);
    drain_results();

    // Random phases: fixed corner settings first, then random ones.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      drain_results();
      case (p)
        0: load_settings(16'd3, 16'd2, 16'd1, 8'd10, 8'd200, 8'd7);
        1: load_settings(16'd1, 16'd0, 16'd2, 8'd200, 8'd50, 8'd0);   // floor over ceiling
        2: load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd255, 8'd255, 8'd1);
        3: load_settings(16'd2, 16'd1, 16'd0, 8'd0, 8'd0, 8'd255);
        default: load_settings(16'($urandom_range(0, 8)), 16'($urandom_range(0, 5)),
                               16'($urandom_range(0, 4)), 8'($urandom),
                               8'($urandom), 8'($urandom));
      endcase
      // Run the last phase with no idling on either side.
      if (p == RANDOM_PHASES - 1) begin
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
      end
      for (int i = 0; i < PHASE_WORDS; i++) begin
        // Hold off the receiver while words keep coming, to fill the block.
        if (p == 1 && i == 60) rx_hold = LONG_HOLD;
        // Pause the sender until all results are back, then resume.
        if (p == 0 && i == 100) drain_results();
        send_random_word();
      end
    end

    drain_results();
    repeat (4) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
